FILE: design/tes_pkg.sv
// Shared constants for the triangle element stiffness block.
`default_nettype none
package tes_pkg;
	localparam int ENTRIES    = 6;
	localparam int VALUE_BITS = 32;
	localparam int QUO_BITS   = VALUE_BITS + 1;
	localparam logic [2:0] LAST_K = 3'd5;
	localparam logic [1:0] PAIR_I [ENTRIES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] PAIR_J [ENTRIES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
	localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
endpackage
`default_nettype wire

FILE: design/tes_front.sv
// Front end: accept a triangle, form edge differences and twice the area.
`default_nettype none
module tes_front #(
	parameter int IDW = 20,
	parameter int CW  = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [((3*IDW+6*CW+7)/8)*8-1:0] in_data,
	output logic                 q_valid,
	input  wire logic            q_ready,
	output logic [3*IDW+6*(CW+1)+2*(CW+1)+2-1:0] q_data
);
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * DW;
	localparam int HW   = PW + 1;
	localparam int EW   = 3*IDW + 6*DW + HW + 1;

	logic signed [DW-1:0] x [3];
	logic signed [DW-1:0] y [3];
	logic v_s1, v_s2, adv;
	logic [IDW-1:0] id_s1 [3];
	logic [IDW-1:0] id_s2 [3];
	logic signed [DW-1:0] b_s1 [3];
	logic signed [DW-1:0] c_s1 [3];
	logic signed [DW-1:0] b_s2 [3];
	logic signed [DW-1:0] c_s2 [3];
	logic signed [DW-1:0] dx1_s1, dy2_s1, dx2_s1, dy1_s1;
	logic signed [PW-1:0] p1_s2, p2_s2;
	logic signed [HW-1:0] det;
	logic [HW-1:0] half;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			x[i] = DW'($signed(in_data[3*IDW + 2*i*CW +: CW]));
			y[i] = DW'($signed(in_data[3*IDW + 2*i*CW + CW +: CW]));
		end
	end

	assign adv      = !v_s2 || q_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				id_s1[i] <= in_data[i*IDW +: IDW];
				id_s2[i] <= id_s1[i];
				b_s2[i]  <= b_s1[i];
				c_s2[i]  <= c_s1[i];
			end
			b_s1[0] <= y[1] - y[2];
			b_s1[1] <= y[2] - y[0];
			b_s1[2] <= y[0] - y[1];
			c_s1[0] <= x[2] - x[1];
			c_s1[1] <= x[0] - x[2];
			c_s1[2] <= x[1] - x[0];
			dx1_s1  <= x[1] - x[0];
			dy2_s1  <= y[2] - y[0];
			dx2_s1  <= x[2] - x[0];
			dy1_s1  <= y[1] - y[0];
			p1_s2   <= PW'(dx1_s1 * dy2_s1);
			p2_s2   <= PW'(dx2_s1 * dy1_s1);
		end
	end

	assign det  = HW'(p1_s2) - HW'(p2_s2);
	assign half = det[HW-1] ? HW'(-det) : HW'(det);

	assign q_valid = v_s2;
	assign q_data  = EW'({(det == '0), half, c_s2[2], c_s2[1], c_s2[0],
		b_s2[2], b_s2[1], b_s2[0], id_s2[2], id_s2[1], id_s2[0]});
endmodule
`default_nettype wire

FILE: design/tes_queue.sv
// Two-entry queue between front and back ends.
`default_nettype none
module tes_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_valid,
	output logic              wr_ready,
	input  wire logic [W-1:0] wr_data,
	output logic              rd_valid,
	input  wire logic         rd_pop,
	output logic [W-1:0]      rd_data
);
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

FILE: design/tes_back.sv
// Back end: issue six entries per triangle and divide in a bit-per-stage pipeline.
`default_nettype none
module tes_back #(
	parameter int IDW  = 20,
	parameter int CW   = 16,
	parameter int FRAC = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic      q_pop,
	input  wire logic [3*IDW+6*(CW+1)+2*(CW+1)+2-1:0] q_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [IDW-1:0] out_row,
	output logic [IDW-1:0] out_col,
	output logic [tes_pkg::VALUE_BITS-1:0] out_value,
	output logic      out_degen,
	output logic      out_last
);
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int HW  = PW + 1;
	localparam int NW  = PW + 1;
	localparam int RW  = HW + 2;
	localparam int QB  = tes_pkg::QUO_BITS;
	localparam int VB  = tes_pkg::VALUE_BITS;
	localparam int NPW = QB + RW;

	logic be, issue;
	logic [2:0] k_q;
	logic [IDW-1:0] qid [3];
	logic signed [DW-1:0] qb [3];
	logic signed [DW-1:0] qc [3];
	logic [HW-1:0] qhalf;
	logic qdegen;
	logic [1:0] pi, pj;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0] bi_s1, bj_s1, ci_s1, cj_s1;
	logic [IDW-1:0] ida_s1, idb_s1;
	logic [IDW-1:0] lo_s2, hi_s2, lo_s3, hi_s3, lo_s4, hi_s4, lo_s5, hi_s5;
	logic [HW-1:0] half_s1, half_s2, half_s3;
	logic dg_s1, dg_s2, dg_s3, dg_s4, dg_s5;
	logic ls_s1, ls_s2, ls_s3, ls_s4, ls_s5;
	logic signed [PW-1:0] bb_s2, cc_s2;
	logic signed [NW-1:0] num_s3;
	logic [NW-1:0] mag;
	logic neg_s4, neg_s5;
	logic [NPW-1:0] n_s4;
	logic [RW-1:0] dd_s4, dd_s5, rem_s5;
	logic [QB-1:0] nq_s5;
	logic ovf_s5;

	logic          dv_s6  [QB];
	logic [RW-1:0] rem_s6 [QB];
	logic [RW-1:0] dd_s6  [QB];
	logic [QB-1:0] nq_s6  [QB];
	logic [IDW-1:0] lo_s6 [QB];
	logic [IDW-1:0] hi_s6 [QB];
	logic          dg_s6  [QB];
	logic          ls_s6  [QB];
	logic          neg_s6 [QB];
	logic          ovf_s6 [QB];

	logic [QB-1:0] quo;
	logic sat_p, sat_n, fneg;
	logic [VB-1:0] val;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qid[i] = q_data[i*IDW +: IDW];
			qb[i]  = q_data[3*IDW + i*DW +: DW];
			qc[i]  = q_data[3*IDW + (3+i)*DW +: DW];
		end
	end
	assign qhalf  = q_data[3*IDW + 6*DW +: HW];
	assign qdegen = q_data[3*IDW + 6*DW + HW];
	assign pi     = tes_pkg::PAIR_I[k_q];
	assign pj     = tes_pkg::PAIR_J[k_q];

	assign be    = !out_valid || out_ready;
	assign issue = be && q_valid;
	assign q_pop = issue && (k_q == tes_pkg::LAST_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (be) begin
			if (issue) k_q <= (k_q == tes_pkg::LAST_K) ? 3'd0 : k_q + 3'd1;
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid <= dv_s6[QB-1];
		end
	end

	assign mag = num_s3[NW-1] ? NW'(-num_s3) : NW'(num_s3);

	always_ff @(posedge clk) begin
		if (be) begin
			bi_s1   <= qb[pi];
			bj_s1   <= qb[pj];
			ci_s1   <= qc[pi];
			cj_s1   <= qc[pj];
			ida_s1  <= qid[pi];
			idb_s1  <= qid[pj];
			half_s1 <= qhalf;
			dg_s1   <= qdegen;
			ls_s1   <= (k_q == tes_pkg::LAST_K);

			bb_s2   <= PW'(bi_s1 * bj_s1);
			cc_s2   <= PW'(ci_s1 * cj_s1);
			lo_s2   <= (ida_s1 < idb_s1) ? ida_s1 : idb_s1;
			hi_s2   <= (ida_s1 < idb_s1) ? idb_s1 : ida_s1;
			half_s2 <= half_s1;
			dg_s2   <= dg_s1;
			ls_s2   <= ls_s1;

			num_s3  <= NW'(bb_s2) + NW'(cc_s2);
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
			half_s3 <= half_s2;
			dg_s3   <= dg_s2;
			ls_s3   <= ls_s2;

			neg_s4  <= num_s3[NW-1];
			n_s4    <= (NPW'(mag) << FRAC) + NPW'(half_s3);
			dd_s4   <= RW'(half_s3) << 1;
			lo_s4   <= lo_s3;
			hi_s4   <= hi_s3;
			dg_s4   <= dg_s3;
			ls_s4   <= ls_s3;

			rem_s5  <= n_s4[NPW-1:QB];
			nq_s5   <= n_s4[QB-1:0];
			ovf_s5  <= (n_s4[NPW-1:QB] >= dd_s4);
			dd_s5   <= dd_s4;
			neg_s5  <= neg_s4;
			lo_s5   <= lo_s4;
			hi_s5   <= hi_s4;
			dg_s5   <= dg_s4;
			ls_s5   <= ls_s4;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [RW-1:0] rin, din, t;
		logic [QB-1:0] nin;
		logic vin, ge;
		logic [IDW-1:0] loin, hiin;
		logic dgin, lsin, ngin, ovin;

		if (j == 0) begin : g_first
			assign vin  = v_s5;
			assign rin  = rem_s5;
			assign din  = dd_s5;
			assign nin  = nq_s5;
			assign loin = lo_s5;
			assign hiin = hi_s5;
			assign dgin = dg_s5;
			assign lsin = ls_s5;
			assign ngin = neg_s5;
			assign ovin = ovf_s5;
		end else begin : g_next
			assign vin  = dv_s6[j-1];
			assign rin  = rem_s6[j-1];
			assign din  = dd_s6[j-1];
			assign nin  = nq_s6[j-1];
			assign loin = lo_s6[j-1];
			assign hiin = hi_s6[j-1];
			assign dgin = dg_s6[j-1];
			assign lsin = ls_s6[j-1];
			assign ngin = neg_s6[j-1];
			assign ovin = ovf_s6[j-1];
		end

		assign t  = {rin[RW-2:0], nin[QB-1]};
		assign ge = (t >= din);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s6[j] <= 1'b0;
			end else if (be) begin
				dv_s6[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (be) begin
				rem_s6[j] <= ge ? t - din : t;
				nq_s6[j]  <= {nin[QB-2:0], ge};
				dd_s6[j]  <= din;
				lo_s6[j]  <= loin;
				hi_s6[j]  <= hiin;
				dg_s6[j]  <= dgin;
				ls_s6[j]  <= lsin;
				neg_s6[j] <= ngin;
				ovf_s6[j] <= ovin;
			end
		end
	end

	assign quo   = nq_s6[QB-1];
	assign fneg  = neg_s6[QB-1];
	assign sat_p = ovf_s6[QB-1] || quo[QB-1] || quo[QB-2];
	assign sat_n = ovf_s6[QB-1] || quo[QB-1] || (quo[QB-2] && (|quo[QB-3:0]));

	always_comb begin
		if (dg_s6[QB-1]) begin
			val = '0;
		end else if (!fneg) begin
			val = sat_p ? tes_pkg::VAL_MAX : quo[VB-1:0];
		end else begin
			val = sat_n ? tes_pkg::VAL_MIN : VB'(-quo[VB-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			out_row   <= lo_s6[QB-1];
			out_col   <= hi_s6[QB-1];
			out_value <= val;
			out_degen <= dg_s6[QB-1];
			out_last  <= ls_s6[QB-1];
		end
	end
endmodule
`default_nettype wire

FILE: design/triangle_element_stiffness.sv
// Top level of the triangle element stiffness block.
// Pipeline: 2 front stages, the queue, 5 back stages, 33 divide stages, 1 output
// register, from triangle word to its first entry word.
// Six entries per triangle, one per cycle while queued and output not stalled.
// A two-triangle queue lets the front take words while the back is stalled.
// arst_n clears all valid bits, the queue and the entry counter.
`default_nettype none
module triangle_element_stiffness #(
	parameter int VERTEX_ID_BITS  = 20,
	parameter int COORD_BITS      = 16,
	parameter int VALUE_FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// vertex_a_id, vertex_b_id, vertex_c_id, vertex_a_x, vertex_a_y,
	// vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
	input  wire logic [((3*VERTEX_ID_BITS+6*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// row_index, col_index, stiffness_value
	output logic [((2*VERTEX_ID_BITS+tes_pkg::VALUE_BITS+7)/8)*8-1:0] m_tdata,
	// degenerate
	output logic      m_tuser,
	output logic      m_tlast
);
	localparam int IDW = VERTEX_ID_BITS;
	localparam int DW  = COORD_BITS + 1;
	localparam int EW  = 3*IDW + 6*DW + 2*DW + 2;
	localparam int OW  = ((2*IDW + tes_pkg::VALUE_BITS + 7) / 8) * 8;

	logic fq_valid, fq_ready, bq_valid, bq_pop;
	logic [EW-1:0] fq_data, bq_data;
	logic [IDW-1:0] row, col;
	logic [tes_pkg::VALUE_BITS-1:0] value;

	tes_front #(.IDW(IDW), .CW(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
	);

	tes_queue #(.W(EW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(bq_valid), .rd_pop(bq_pop), .rd_data(bq_data)
	);

	tes_back #(.IDW(IDW), .CW(COORD_BITS), .FRAC(VALUE_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(bq_valid), .q_pop(bq_pop), .q_data(bq_data),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_row(row), .out_col(col), .out_value(value),
		.out_degen(m_tuser), .out_last(m_tlast)
	);

	assign m_tdata = OW'({value, col, row});
endmodule
`default_nettype wire

FILE: design/tes_checker.sv
// Port checker for the triangle element stiffness block.
`default_nettype none
module tes_checker #(
	parameter int VERTEX_ID_BITS = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [((2*VERTEX_ID_BITS+tes_pkg::VALUE_BITS+7)/8)*8-1:0] m_tdata,
	input wire logic m_tuser,
	input wire logic m_tlast
);
	localparam int IDW = VERTEX_ID_BITS;

	a_row_le_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[IDW-1:0] <= m_tdata[2*IDW-1:IDW]))
		else $error("row above col");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[2*IDW +: tes_pkg::VALUE_BITS] == '0))
		else $error("degenerate word with nonzero value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("output word changed while stalled");

	a_no_early_out: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output word right after reset");
endmodule

bind triangle_element_stiffness tes_checker #(
	.VERTEX_ID_BITS(VERTEX_ID_BITS)
) u_tes_checker (.*);
`default_nettype wire

FILE: bench/tes_checker.sv
// Checker for the triangle element stiffness block: predicts entry words and compares them.
`timescale 1ns / 1ps
module tes_scoreboard (
	input  wire logic         clk,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [159:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [71:0]  m_tdata,
	input  wire logic         m_tuser,
	input  wire logic         m_tlast,
	output int                failures,
	output int                pending,
	output int                triangles,
	output int                entry_words,
	output int                degenerate_tris
);
	typedef struct packed {
		logic [19:0] row;
		logic [19:0] col;
		logic [31:0] value;
		logic        degen;
		logic        last;
	} entry_t;

	entry_t entry_q[$];

	initial begin
		failures = 0;
		pending = 0;
		triangles = 0;
		entry_words = 0;
		degenerate_tris = 0;
	end

	function automatic void predict_entries(input logic [159:0] d);
		logic [19:0] id[3];
		longint x[3], y[3], b[3], c[3];
		longint det, half, num, mag, quo;
		logic neg, degen;
		int p, q;
		entry_t e;
		for (int i = 0; i < 3; i++) begin
			id[i] = d[20*i +: 20];
			x[i] = longint'($signed(d[60+32*i +: 16]));
			y[i] = longint'($signed(d[76+32*i +: 16]));
		end
		for (int i = 0; i < 3; i++) begin
			b[i] = y[(i+1)%3] - y[(i+2)%3];
			c[i] = x[(i+2)%3] - x[(i+1)%3];
		end
		det = (x[1]-x[0])*(y[2]-y[0]) - (x[2]-x[0])*(y[1]-y[0]);
		half = det < 0 ? -det : det;
		degen = (half == 0);
		if (degen)
			degenerate_tris++;
		for (int k = 0; k < tes_pkg::ENTRIES; k++) begin
			p = int'(tes_pkg::PAIR_I[k]);
			q = int'(tes_pkg::PAIR_J[k]);
			e.value = '0;
			if (!degen) begin
				num = b[p]*b[q] + c[p]*c[q];
				neg = num < 0;
				mag = (neg ? -num : num) <<< 16;
				quo = (mag + half) / (2*half);
				if (!neg)
					e.value = quo > 64'sh7FFFFFFF ? tes_pkg::VAL_MAX : quo[31:0];
				else
					e.value = quo > 64'sh80000000 ? tes_pkg::VAL_MIN : 32'(-quo);
			end
			e.row = id[p] < id[q] ? id[p] : id[q];
			e.col = id[p] < id[q] ? id[q] : id[p];
			e.degen = degen;
			e.last = (k == int'(tes_pkg::LAST_K));
			entry_q = {entry_q, e};
		end
	endfunction

	always @(posedge clk) begin
		entry_t want;
		if (s_tvalid && s_tready) begin
			triangles++;
			predict_entries(s_tdata);
		end
		if (m_tvalid && m_tready) begin
			entry_words++;
			if (entry_q.size() == 0) begin
				$error("entry word with nothing expected: %h", m_tdata);
				failures++;
			end else begin
				want = entry_q.pop_front();
				if (m_tdata[19:0] !== want.row) begin
					$error("row_index: expected %0d, got %0d", want.row, m_tdata[19:0]);
					failures++;
				end
				if (m_tdata[39:20] !== want.col) begin
					$error("col_index: expected %0d, got %0d", want.col, m_tdata[39:20]);
					failures++;
				end
				if (m_tdata[71:40] !== want.value) begin
					$error("stiffness_value: expected %h, got %h", want.value,
						m_tdata[71:40]);
					failures++;
				end
				if (m_tuser !== want.degen) begin
					$error("degenerate: expected %b, got %b", want.degen, m_tuser);
					failures++;
				end
				if (m_tlast !== want.last) begin
					$error("last_entry: expected %b, got %b", want.last, m_tlast);
					failures++;
				end
			end
		end
		pending = entry_q.size();
	end
endmodule

FILE: bench/tb_top.sv
// Testbench top for the triangle element stiffness block: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic         m_tuser;
	logic         m_tlast;
	int           failures, pending, triangles, entry_words, degenerate_tris;
	int           send_idle_pct, recv_stall_pct;

	localparam int KIND_FULL     = 0;
	localparam int KIND_SMALL    = 1;
	localparam int KIND_LINE     = 2;
	localparam int KIND_REPEAT   = 3;
	localparam int KIND_THIN     = 4;

	triangle_element_stiffness u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	tes_scoreboard u_checker (
		.clk(clk), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast), .failures(failures),
		.pending(pending), .triangles(triangles), .entry_words(entry_words),
		.degenerate_tris(degenerate_tris)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		m_tready = 1'b0;
		recv_stall_pct = 0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [159:0] pack_tri(input logic [19:0] ia, ib, ic,
		input logic [15:0] ax, ay, bx, by, cx, cy);
		return {4'd0, cy, cx, by, bx, ay, ax, ic, ib, ia};
	endfunction

	function automatic logic [159:0] random_tri(input int kind);
		logic [19:0] id[3];
		logic signed [15:0] x[3], y[3];
		int dx, dy;
		for (int i = 0; i < 3; i++) begin
			id[i] = 20'($urandom);
			x[i] = 16'($urandom);
			y[i] = 16'($urandom);
		end
		case (kind)
			KIND_SMALL: begin
				for (int i = 0; i < 3; i++) begin
					x[i] = 16'($urandom_range(512) - 256);
					y[i] = 16'($urandom_range(512) - 256);
				end
			end
			KIND_LINE: begin
				x[0] = 16'($urandom_range(2000) - 1000);
				y[0] = 16'($urandom_range(2000) - 1000);
				dx = $urandom_range(2000) - 1000;
				dy = $urandom_range(2000) - 1000;
				x[1] = 16'(x[0] + dx);
				y[1] = 16'(y[0] + dy);
				x[2] = 16'(x[0] + 2*dx);
				y[2] = 16'(y[0] + 2*dy);
			end
			KIND_REPEAT: begin
				x[2] = x[$urandom_range(1)];
				y[2] = y[0];
				x[2] = x[0];
				id[1] = id[0];
			end
			KIND_THIN: begin
				y[1] = 16'(y[0] + $urandom_range(2));
				y[2] = 16'(y[0] + $urandom_range(2));
			end
			default: ;
		endcase
		return pack_tri(id[0], id[1], id[2], x[0], y[0], x[1], y[1], x[2], y[2]);
	endfunction

	task automatic send_tri(input logic [159:0] d);
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic send_random(input int n);
		int r, kind;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			kind = r < 35 ? KIND_FULL : r < 60 ? KIND_SMALL : r < 75 ? KIND_LINE
				: r < 85 ? KIND_REPEAT : KIND_THIN;
			send_tri(random_tri(kind));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tri(pack_tri(20'd0, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		send_tri(pack_tri(20'd1, 20'd2, 20'd3, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0,
			16'd256));
		send_tri(pack_tri(20'd9, 20'd5, 20'd7, 16'd0, 16'd0, 16'd0, 16'd256, 16'd256,
			16'd0));
		send_tri(pack_tri(20'hFFFFF, 20'd0, 20'hFFFFF, 16'h8000, 16'h8000, 16'h7FFF,
			16'h8000, 16'h8000, 16'h7FFF));
		send_tri(pack_tri(20'hFFFFF, 20'hFFFFE, 20'd0, 16'h7FFF, 16'h7FFF, 16'h8000,
			16'h7FFF, 16'h7FFF, 16'h8000));
		send_tri(pack_tri(20'd4, 20'd4, 20'd4, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'h8000,
			16'd1));
		send_tri(pack_tri(20'd10, 20'd11, 20'd12, 16'h8000, 16'd0, 16'h7FFF, 16'd1,
			16'd0, 16'd0));
		send_tri(pack_tri(20'd3, 20'd2, 20'd1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0,
			16'd1));
		send_tri(pack_tri(20'd6, 20'd7, 20'd8, 16'd0, 16'd0, 16'd100, 16'd100,
			16'd200, 16'd200));
		send_tri(pack_tri(20'd6, 20'd7, 20'd8, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h7FFF, 16'h7FFF));
		send_tri(pack_tri(20'hAAAAA, 20'h55555, 20'd0, 16'hAAAA, 16'h5555, 16'h5555,
			16'hAAAA, 16'hFFFF, 16'd0));

		send_idle_pct = 25;
		recv_stall_pct = 76;
		send_random(146);
		send_idle_pct = 76;
		recv_stall_pct = 25;
		send_random(146);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random(146);
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d triangles (%0d degenerate), %0d entry words checked",
			triangles, degenerate_tris, entry_words);
		$display("stimulus: extreme corners, collinear, repeated vertices, thin slivers");
		if (failures == 0)
			$display("triangle_element_stiffness regression: pass");
		else
			$display("triangle_element_stiffness regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("triangle_element_stiffness regression: fail");
		$finish;
	end
endmodule
